// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the block.
// Both forms sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cma_pkg.sv =====
`timescale 1ns / 1ps

package cma_pkg;

    // Field and register widths.
    localparam int SAMPLE_W       = 16;
    localparam int AVG_W          = 24;
    localparam int WC_W           = 7;
    localparam int SEEN_W         = 7;
    localparam int FRAC_W         = 8;
    localparam int RECIP_W        = 32;
    localparam int RECIP_SHIFT    = 32;
    localparam int APB_ADDR_W     = 2;
    localparam int APB_DATA_W     = 32;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [WC_W-1:0]       WC_RESET          = 7'd10;
    localparam logic [SEEN_W-1:0]     SEEN_LIMIT        = 7'd127;
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_COUNT = 2'd0;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DIV_WAIT,
        ST_PRESENT,
        ST_FLUSH_READ,
        ST_FLUSH_SUM
    } cma_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic update;
        logic div_start;
        logic load_out;
        logic out_last;
        logic flush_read;
        logic flush_step;
        logic flush_next;
        logic finish;
    } cma_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_now;
        logic last_item;
        logic emit_k;
        logic k_last;
        logic div_done;
        logic out_free;
    } cma_stat_t;

endpackage

// ===== rtl/core/cma_div.sv =====
`timescale 1ns / 1ps

module cma_div #(
    parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF,
    localparam int SUM_W = $clog2(MAX_WINDOW) + 17,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [SUM_W-1:0]     sum,
    input  logic [CNT_W-1:0]            n,
    output logic                        done,
    output logic [cma_pkg::AVG_W-1:0]   quotient
);
    import cma_pkg::*;

    localparam int A_W    = SUM_W + FRAC_W;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QN_W   = A_W + CNT_W;
    localparam int SHIFT  = RECIP_SHIFT - FRAC_W;

    logic [RECIP_W-1:0] recip_tab [0:MAX_WINDOW];

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [SUM_W-1:0]   mag1_reg, mag2_reg;
    logic [RECIP_W-1:0] recip1_reg;
    logic [CNT_W-1:0]   n1_reg, n2_reg, n3_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [A_W-1:0]     q0_3_reg;
    logic [QN_W-1:0]    qn3_reg;
    logic [A_W-1:0]     a3_reg;
    logic [AVG_W-1:0]   q_reg;

    logic [QN_W-1:0]    rem;
    logic [A_W-1:0]     q_fix;
    logic [A_W-1:0]     q_neg;
    logic [AVG_W-1:0]   q_next;

    // Reciprocal table: floor(2^32 / n), worked out at elaboration.
    for (genvar i = 0; i <= MAX_WINDOW; i++) begin : g_recip
        localparam logic [63:0] RI = (64'd1 << RECIP_SHIFT) / ((i < 2) ? 64'd2 : 64'(i));
        assign recip_tab[i] = RI[RECIP_W-1:0];
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Final correction: the estimate is at most one below the true quotient.
    always_comb
    begin
        rem    = QN_W'(a3_reg) - qn3_reg;
        q_fix  = q0_3_reg + A_W'(rem >= QN_W'(n3_reg));
        q_neg  = -q_fix;
        q_next = neg3_reg ? q_neg[AVG_W-1:0] : q_fix[AVG_W-1:0];
    end

    // Datapath stages: magnitude, reciprocal product, back-multiply, correct.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg1_reg   <= sum[SUM_W-1];
            mag1_reg   <= sum[SUM_W-1] ? unsigned'(-sum) : unsigned'(sum);
            recip1_reg <= recip_tab[n];
            n1_reg     <= n;
        end
        if (v1_reg)
        begin
            prod2_reg <= PROD_W'(mag1_reg) * PROD_W'(recip1_reg);
            mag2_reg  <= mag1_reg;
            n2_reg    <= n1_reg;
            neg2_reg  <= neg1_reg;
        end
        if (v2_reg)
        begin
            q0_3_reg <= prod2_reg[PROD_W-1:SHIFT];
            qn3_reg  <= QN_W'(prod2_reg[PROD_W-1:SHIFT]) * QN_W'(n2_reg);
            a3_reg   <= {mag2_reg, FRAC_W'(0)};
            n3_reg   <= n2_reg;
            neg3_reg <= neg2_reg;
        end
        if (v3_reg)
        begin
            q_reg <= q_next;
        end
    end

    assign done     = v4_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/core/cma_datapath.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cma_datapath #(
    parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF,
    localparam int SUM_W = $clog2(MAX_WINDOW) + 17,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int AW    = $clog2(MAX_WINDOW)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cma_pkg::WC_W-1:0]          window_count,
    input  logic signed [cma_pkg::SAMPLE_W-1:0] sample,
    input  logic                              is_last,
    input  cma_pkg::cma_cmd_t                 cmd,
    output cma_pkg::cma_stat_t                stat,
    input  logic                              result_stall,
    output logic                              result_valid,
    output logic [cma_pkg::AVG_W-1:0]         average,
    output logic                              last_out
);
    import cma_pkg::*;

    localparam int PW = CNT_W + 1;
    localparam int KW = SEEN_W + 1;
    localparam int FP_W = SAMPLE_W + CNT_W + 1;

    // Sample ring.
    logic signed [SAMPLE_W-1:0] store_mem [0:MAX_WINDOW-1];
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic [AW-1:0]              raddr;

    // Sequence state.
    logic signed [SUM_W-1:0]    sum_reg;
    logic [AW-1:0]              wp_reg;
    logic [SEEN_W-1:0]          seen_reg;
    logic signed [SAMPLE_W-1:0] first_reg;
    logic                       started_reg;
    logic [CNT_W-1:0]           n_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic                       first_flag_reg;
    logic [CNT_W-1:0]           k_reg;

    // Output register.
    logic                       result_valid_reg;
    logic [AVG_W-1:0]           average_reg;
    logic                       last_out_reg;

    logic [CNT_W-1:0]           n_clamp;
    logic signed [FP_W-1:0]     first_prod;
    logic [CNT_W-1:0]           h;
    logic [PW-1:0]              main_t, flush_t, addr_t;
    logic signed [SAMPLE_W-1:0] old_main, old_flush;
    logic [SEEN_W-1:0]          seen_m1;
    logic [KW-1:0]              seen_k;
    logic                       out_free;
    logic                       div_done;
    logic [AVG_W-1:0]           div_q;

    // Window length is clamped into the supported range.
    always_comb
    begin
        priority if (window_count < WC_W'(2))
            n_clamp = CNT_W'(2);
        else if (window_count > WC_W'(MAX_WINDOW))
            n_clamp = CNT_W'(MAX_WINDOW);
        else
            n_clamp = CNT_W'(window_count);
    end

    assign first_prod = $signed({1'b0, n_clamp}) * sample;
    assign h          = n_reg >> 1;

    // Ring addresses: the sample leaving the window, and the flush lookback.
    always_comb
    begin
        main_t  = PW'(wp_reg) + PW'(MAX_WINDOW) - PW'(n_reg);
        flush_t = PW'(wp_reg) + PW'(MAX_WINDOW) - PW'(1) - PW'(n_reg) + PW'(k_reg);
        addr_t  = cmd.flush_read ? flush_t : main_t;
        if (addr_t >= PW'(MAX_WINDOW))
            addr_t = addr_t - PW'(MAX_WINDOW);
        raddr = addr_t[AW-1:0];
    end

    // Before a full window, the leaving sample is a copy of the first one.
    assign seen_k    = KW'(seen_reg) + KW'(k_reg);
    assign old_main  = (seen_reg < SEEN_W'(n_reg)) ? first_reg : rdata_reg;
    assign old_flush = (seen_k <= KW'(n_reg)) ? first_reg : rdata_reg;
    assign seen_m1   = (seen_reg == SEEN_LIMIT) ? (SEEN_LIMIT - SEEN_W'(1)) : seen_reg;

    assign out_free = !result_valid_reg || !result_stall;

    // Status toward the controller.
    always_comb
    begin
        stat.emit_now  = seen_m1 >= SEEN_W'(h);
        stat.last_item = last_reg;
        stat.emit_k    = seen_k >= (KW'(h) + KW'(1));
        stat.k_last    = k_reg == h;
        stat.div_done  = div_done;
        stat.out_free  = out_free;
    end

    // Ring write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            store_mem[wp_reg] <= x_reg;
        rdata_reg <= store_mem[raddr];
    end

    // Sequence state updates.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            wp_reg         <= '0;
            seen_reg       <= '0;
            first_reg      <= '0;
            started_reg    <= 1'b0;
            n_reg          <= '0;
            x_reg          <= '0;
            last_reg       <= 1'b0;
            first_flag_reg <= 1'b0;
            k_reg          <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                x_reg          <= sample;
                last_reg       <= is_last;
                k_reg          <= CNT_W'(1);
                first_flag_reg <= !started_reg;
                if (!started_reg)
                begin
                    n_reg       <= n_clamp;
                    first_reg   <= sample;
                    sum_reg     <= first_prod[SUM_W-1:0];
                    seen_reg    <= '0;
                    wp_reg      <= '0;
                    started_reg <= 1'b1;
                end
            end
            if (cmd.update)
            begin
                if (!first_flag_reg)
                    sum_reg <= sum_reg + SUM_W'(x_reg) - SUM_W'(old_main);
                wp_reg   <= (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
                if (seen_reg != SEEN_LIMIT)
                    seen_reg <= seen_reg + SEEN_W'(1);
            end
            if (cmd.flush_step)
                sum_reg <= sum_reg + SUM_W'(x_reg) - SUM_W'(old_flush);
            if (cmd.flush_next)
                k_reg <= k_reg + CNT_W'(1);
            if (cmd.finish)
            begin
                sum_reg     <= '0;
                wp_reg      <= '0;
                seen_reg    <= '0;
                started_reg <= 1'b0;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            average_reg  <= div_q;
            last_out_reg <= cmd.out_last;
        end
    end

    cma_div #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .sum      (sum_reg),
        .n        (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign result_valid = result_valid_reg;
    assign average      = average_reg;
    assign last_out     = last_out_reg;

    `CMA_ASSERT_NOW(a_load_when_free, cmd.load_out, out_free, "result loaded over a pending transaction")
    `CMA_ASSERT_NOW(a_wp_in_ring, 1'b1, PW'(wp_reg) < PW'(MAX_WINDOW), "write position outside the ring")
    `CMA_ASSERT_NOW(a_k_in_range, cmd.flush_step, (k_reg >= CNT_W'(1)) && (k_reg <= h), "flush step beyond half a window")

endmodule

// ===== rtl/core/cma_ctrl.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cma_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  cma_pkg::cma_stat_t stat,
    output cma_pkg::cma_cmd_t  cmd
);
    import cma_pkg::*;

    cma_state_t state_reg, state_next;
    logic       flushing_reg, flushing_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            flushing_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            flushing_reg <= flushing_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        flushing_next = flushing_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.accept    = 1'b1;
                    flushing_next = 1'b0;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (stat.emit_now)
                    state_next = ST_DIV;
                else if (stat.last_item)
                begin
                    flushing_next = 1'b1;
                    state_next    = ST_FLUSH_READ;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_PRESENT;
            end
            ST_PRESENT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = flushing_reg && stat.k_last;
                    if (flushing_reg)
                    begin
                        if (stat.k_last)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.flush_next = 1'b1;
                            state_next     = ST_FLUSH_READ;
                        end
                    end
                    else if (stat.last_item)
                    begin
                        flushing_next = 1'b1;
                        state_next    = ST_FLUSH_READ;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FLUSH_READ:
            begin
                cmd.flush_read = 1'b1;
                state_next     = ST_FLUSH_SUM;
            end
            ST_FLUSH_SUM:
            begin
                cmd.flush_step = 1'b1;
                if (stat.emit_k)
                    state_next = ST_DIV;
                else if (stat.k_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.flush_next = 1'b1;
                    state_next     = ST_FLUSH_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign sample_stall = state_reg != ST_IDLE;

    `CMA_ASSERT_NOW(a_done_in_wait, stat.div_done, state_reg == ST_DIV_WAIT, "divider finished outside its wait state")
    `CMA_ASSERT_NOW(a_flush_only_last, flushing_reg, stat.last_item, "flush running for an item not marked last")
    `CMA_ASSERT_NEXT(a_final_to_idle, cmd.load_out && cmd.out_last, state_reg == ST_IDLE, "final result did not end the sequence")

endmodule

// ===== rtl/core/centered_moving_average_top.sv =====
`timescale 1ns / 1ps

// Channel    Handshake                      Payload
// sample     sample_valid / sample_stall    sample[15:0] signed, is_last
// result     result_valid / result_stall    average[23:0] signed Q.8, last_out
// config     psel, penable, pwrite, pready  paddr, pwdata, prdata (window_count)
//
// An item that yields no result only updates the ring and running sum; one that yields
// a result then passes through the four-stage reciprocal divider behind that update.
// Each flushed result after the last sample goes through ring read, sum update,
// divide and present in turn; a last item with h = window/2 has up to h flush steps.
// Reset clears the sequence state and the output valid; window_count resets to 10.
// A stalled result is held in the output register; a new sample is still taken
// when the block is idle, and a new result waits only for that register to drain.

module centered_moving_average_top #(
    parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [cma_pkg::SAMPLE_W-1:0] sample,
    input  logic                                is_last,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [cma_pkg::AVG_W-1:0]           average,
    output logic                                last_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cma_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cma_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cma_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import cma_pkg::*;

    logic [WC_W-1:0] window_count_reg;
    logic            cfg_write;
    cma_cmd_t        cmd;
    cma_stat_t       stat;

    // Configuration register, written on the access phase of a write transaction.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            window_count_reg <= WC_RESET;
        end
        else if (cfg_write)
        begin
            window_count_reg <= pwdata[WC_W-1:0];
        end
    end

    // Read back.
    assign prdata = (paddr == ADDR_WINDOW_COUNT) ? APB_DATA_W'(window_count_reg) : '0;

    cma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    cma_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_count (window_count_reg),
        .sample       (sample),
        .is_last      (is_last),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .average      (average),
        .last_out     (last_out)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// One expected window mean, as the block should present it.
typedef struct packed {
    logic [23:0] average;
    logic        last_out;
} mean_item_t;

// Tracks the sequence state and holds the window means still owed by the block.
class average_scoreboard;
    localparam int RING_DEPTH = cma_pkg::MAX_WINDOW_DEF;
    localparam int SEEN_SAT   = 127;

    int         window_reg;
    int         ring [RING_DEPTH];
    longint     window_sum;
    int         ring_pos;
    int         seen;
    int         first_value;
    bit         in_sequence;
    int         latched_len;
    mean_item_t pending_means [$];
    int         errors;

    function new();
        window_reg  = 10;
        window_sum  = 0;
        ring_pos    = 0;
        seen        = 0;
        first_value = 0;
        in_sequence = 0;
        latched_len = 0;
        errors      = 0;
    endfunction

    function void set_window(int value);
        window_reg = value & 'h7F;
    endfunction

    // Queue the mean of the current window sum, truncated toward zero.
    function void push_mean(bit last);
        longint     q;
        mean_item_t m;
        q = (window_sum * 256) / latched_len;
        m.average  = q[23:0];
        m.last_out = last;
        pending_means.push_back(m);
    endfunction

    // Called for every accepted sample transaction.
    function void note_input(logic signed [15:0] sample, bit last);
        int xv;
        int old;
        int half;
        int k;
        xv = sample;
        if (!in_sequence) begin
            // Window length is latched at the first sample, clamped to 2..64.
            latched_len = (window_reg < 2) ? 2 :
                          (window_reg > RING_DEPTH) ? RING_DEPTH : window_reg;
            first_value = xv;
            window_sum  = longint'(latched_len) * xv;
            seen        = 0;
            ring_pos    = 0;
            in_sequence = 1;
        end else begin
            if (seen < latched_len)
                old = first_value;
            else
                old = ring[(ring_pos + RING_DEPTH - latched_len) % RING_DEPTH];
            window_sum += xv - old;
        end
        half = latched_len / 2;
        ring[ring_pos] = xv;
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        if (seen < SEEN_SAT)
            seen++;
        if (seen - 1 >= half)
            push_mean(0);

        // The last sample flushes the remaining means, padding with itself.
        if (last) begin
            for (k = 1; k <= half; k++) begin
                if (seen + k <= latched_len)
                    old = first_value;
                else
                    old = ring[(ring_pos + RING_DEPTH - 1 - (latched_len - k)) % RING_DEPTH];
                window_sum += xv - old;
                if (seen - 1 + k >= half)
                    push_mean(k == half);
            end
            window_sum  = 0;
            ring_pos    = 0;
            seen        = 0;
            in_sequence = 0;
        end
    endfunction

    // Called for every accepted result transaction.
    function void check_result(logic [23:0] average, logic last_out);
        mean_item_t m;
        if (pending_means.size() == 0) begin
            $display("%0t: unexpected result average=%0d last_out=%0b",
                     $time, $signed(average), last_out);
            errors++;
            return;
        end
        m = pending_means.pop_front();
        if (average !== m.average) begin
            $display("%0t: average mismatch expected=%0d actual=%0d",
                     $time, $signed(m.average), $signed(average));
            errors++;
        end
        if (last_out !== m.last_out) begin
            $display("%0t: last_out mismatch expected=%0b actual=%0b",
                     $time, m.last_out, last_out);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import cma_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
    logic                       result_valid;
    logic                       result_stall;
    logic [AVG_W-1:0]           average;
    logic                       last_out;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    average_scoreboard sb = new();
    bit quiet;
    int samples_sent;
    int stall_left;

    centered_moving_average_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .average      (average),
        .last_out     (last_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Pause lengths: mostly short, a few long.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    // Sample values lean toward the extremes of the 16-bit range.
    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h7FFF;
        else if (r < 20)
            return 16'h8000;
        else if (r < 24)
            return 16'h0000;
        else if (r < 28)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // Random backpressure on the result channel.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            result_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            stall_left = pause_len() - 1;
            result_stall <= 1'b1;
        end else begin
            result_stall <= 1'b0;
        end
    end

    // Check every accepted result transaction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(average, last_out);
    end

    // Send one sample transaction, with an optional idle gap before it.
    task automatic send_sample(logic [15:0] value, bit last);
        int gap;
        gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : pause_len();
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        is_last      <= last;
        do @(posedge clk); while (sample_stall);
        sb.note_input(value, last);
        samples_sent++;
    endtask

    // Wait until every expected mean has come out, then let the block settle.
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.pending_means.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Write window_count, then read it back.
    task automatic write_window(int value);
        logic [31:0] data;
        logic [31:0] wanted;
        data = ($urandom() & 32'hFFFF_FF80) | 32'(value & 'h7F);
        wanted = 32'(value & 'h7F);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW_COUNT;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_window(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== wanted) begin
            $display("%0t: window_count readback expected=%0d actual=%0d",
                     $time, wanted, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Send one sequence of random samples.
    task automatic send_sequence(int len);
        int i;
        for (i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1);
    endtask

    initial
    begin
        int wc;
        int nseq;
        int s;
        int len;
        int r;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        is_last      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        quiet        = 1'b0;
        samples_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting with the reset window length of 10.
        // A lone sample that is also the last one.
        send_sample(16'h7FFF, 1'b1);
        // A sequence shorter than half a window.
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        drain();
        // Window count below the minimum acts as 2.
        write_window(0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        drain();
        // Window count above the maximum acts as 64; full-scale sums.
        write_window(65);
        repeat (5) send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        drain();
        write_window(1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b1);
        drain();

        // Random phases: a window setting, then a few sequences.
        while (samples_sent < 250) begin
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 12)
                wc = 2;
            else if (r < 24)
                wc = 64;
            else if (r < 30)
                wc = $urandom_range(0, 1);
            else if (r < 36)
                wc = $urandom_range(65, 127);
            else if (r < 60)
                wc = $urandom_range(2, 8);
            else
                wc = $urandom_range(2, 64);
            drain();
            write_window(wc);
            if (wc < 2)
                wc = 2;
            if (wc > 64)
                wc = 64;
            nseq = $urandom_range(1, 3);
            for (s = 0; s < nseq && samples_sent < 250; s++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    len = $urandom_range(128, 140);
                else if (r < 30)
                    len = $urandom_range(1, wc / 2);
                else
                    len = $urandom_range(1, (2 * wc + 4 < 40) ? 2 * wc + 4 : 40);
                send_sequence(len);
            end
        end

        quiet = 1'b0;
        drain();
        repeat (24) @(posedge clk);
        if (sb.errors == 0 && sb.pending_means.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
